[sv/display_idle_power_controller_assert.svh]
// Assertion macros for the display idle power controller checker.
// Used by dip_checker; no other dependencies.
`ifndef DISPLAY_IDLE_POWER_CONTROLLER_ASSERT_SVH
`define DISPLAY_IDLE_POWER_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define DIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dip_pkg.sv]
// Shared types and constants for the display idle power controller.
// No dependencies; used by the top level and the checker.
`default_nettype none

package dip_pkg;

    typedef enum logic [1:0] {
        MODE_ACTIVE = 2'd0,
        MODE_DIM    = 2'd1,
        MODE_OFF    = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        OP_POLL     = 3'd0,
        OP_ACTIVITY = 3'd1,
        OP_PRESS    = 3'd2,
        OP_DRAG     = 3'd3,
        OP_SLEEP    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        REG_ACTIVE_TIMEOUT = 3'd0,
        REG_DIM_TIMEOUT    = 3'd1,
        REG_DIM_LEVEL      = 3'd2,
        REG_TAP_WINDOW     = 3'd3,
        REG_SWIPE_DIST     = 3'd4,
        REG_CLOCK_PERIOD   = 3'd5
    } t_reg_idx;

    localparam int TIME_W  = 32;
    localparam int PCT_W   = 7;
    localparam int TAP_W   = 16;
    localparam int SWIPE_W = 10;
    localparam int CLK_W   = 16;
    localparam int OP_W    = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int OUT_W   = 16;

    localparam logic [TIME_W-1:0]  RST_ACTIVE_TIMEOUT = 32'd30000;
    localparam logic [TIME_W-1:0]  RST_DIM_TIMEOUT    = 32'd180000;
    localparam logic [PCT_W-1:0]   RST_DIM_LEVEL      = 7'd15;
    localparam logic [TAP_W-1:0]   RST_TAP_WINDOW     = 16'd350;
    localparam logic [SWIPE_W-1:0] RST_SWIPE_DIST     = 10'd40;
    localparam logic [CLK_W-1:0]   RST_CLOCK_PERIOD   = 16'd1000;

    localparam logic [PCT_W-1:0]   BL_FULL = 7'd100;
    localparam logic [PCT_W-1:0]   BL_NONE = 7'd0;

    // packed from the lowest bit: mode, backlight_pct, refresh, sleep, save
    typedef struct packed {
        logic              save_return_screen;
        logic              light_sleep;
        logic              refresh_clock;
        logic [PCT_W-1:0]  backlight_pct;
        t_mode             mode;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

`default_nettype wire

[sv/display_idle_power_controller.sv]
// An accepted item is registered in the input stage, evaluated from there and
// written into the result queue once it has space; it is offered from the queue.
// Throughput: one item per cycle; a two-entry result queue lets the input side
// keep accepting while a result waits, and stalls it only when both are full.
// Reset (synchronous, active low): mode active, timers and origins zero,
// registers at their defaults, input stage and result queue empty.
`default_nettype none

module display_idle_power_controller #(
    parameter int COORD_WIDTH = 10
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // slave side
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: now_ms[31:0], touch_x, touch_y, touch_seen, zero pad
    input  wire  [((dip_pkg::TIME_W + 2 * COORD_WIDTH + 1 + 7) / 8) * 8 - 1:0]
                                             i_s_axis_tdata,
    // tuser: operation[2:0]
    input  wire  [dip_pkg::OP_W-1:0]         i_s_axis_tuser,
    // master side
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // tdata: mode[1:0], backlight_pct[8:2], refresh_clock[9], light_sleep[10],
    //        save_return_screen[11], zero pad
    output logic [dip_pkg::OUT_W-1:0]        o_m_axis_tdata,
    // configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [dip_pkg::ADDR_W-1:0]       paddr,
    input  wire  [dip_pkg::DATA_W-1:0]       pwdata,
    output logic [dip_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    localparam int DW      = (COORD_WIDTH > dip_pkg::SWIPE_W) ? COORD_WIDTH
                                                              : dip_pkg::SWIPE_W;
    localparam int X_LSB   = dip_pkg::TIME_W;
    localparam int Y_LSB   = dip_pkg::TIME_W + COORD_WIDTH;
    localparam int SEEN_B  = dip_pkg::TIME_W + 2 * COORD_WIDTH;

    // configuration registers
    logic [dip_pkg::TIME_W-1:0]  r_active_to;
    logic [dip_pkg::TIME_W-1:0]  r_dim_to;
    logic [dip_pkg::PCT_W-1:0]   r_dim_level;
    logic [dip_pkg::TAP_W-1:0]   r_tap_window;
    logic [dip_pkg::SWIPE_W-1:0] r_swipe_dist;
    logic [dip_pkg::CLK_W-1:0]   r_clock_period;

    logic                        cfg_wr;
    dip_pkg::t_reg_idx           cfg_idx;

    // input stage
    logic                        r_in_valid;
    dip_pkg::t_op                r_op;
    logic [dip_pkg::TIME_W-1:0]  r_now;
    logic [COORD_WIDTH-1:0]      r_x;
    logic [COORD_WIDTH-1:0]      r_y;
    logic                        r_seen;

    // controller state
    dip_pkg::t_mode              r_mode;
    logic [dip_pkg::TIME_W-1:0]  r_last_act;
    logic [dip_pkg::TIME_W-1:0]  r_last_ref;
    logic [dip_pkg::TIME_W-1:0]  r_last_tap;
    logic [COORD_WIDTH-1:0]      r_org_x;
    logic [COORD_WIDTH-1:0]      r_org_y;
    logic                        r_swipe_done;

    dip_pkg::t_mode              n_mode;
    logic [dip_pkg::TIME_W-1:0]  n_last_act;
    logic [dip_pkg::TIME_W-1:0]  n_last_ref;
    logic [dip_pkg::TIME_W-1:0]  n_last_tap;
    logic [COORD_WIDTH-1:0]      n_org_x;
    logic [COORD_WIDTH-1:0]      n_org_y;
    logic                        n_swipe_done;
    dip_pkg::t_result            n_res;

    // result queue
    dip_pkg::t_result            r_q [2];
    logic                        r_wr_ptr;
    logic                        r_rd_ptr;
    logic [1:0]                  r_cnt;

    logic                        in_acc;
    logic                        proc;
    logic                        pop;
    logic                        q_space;

    logic [dip_pkg::TIME_W-1:0]  dt_act;
    logic [dip_pkg::TIME_W-1:0]  dt_ref;
    logic [dip_pkg::TIME_W-1:0]  dt_tap;
    logic [COORD_WIDTH-1:0]      dx;
    logic [COORD_WIDTH-1:0]      dy;
    logic                        swipe_hit;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = dip_pkg::t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_to    <= dip_pkg::RST_ACTIVE_TIMEOUT;
            r_dim_to       <= dip_pkg::RST_DIM_TIMEOUT;
            r_dim_level    <= dip_pkg::RST_DIM_LEVEL;
            r_tap_window   <= dip_pkg::RST_TAP_WINDOW;
            r_swipe_dist   <= dip_pkg::RST_SWIPE_DIST;
            r_clock_period <= dip_pkg::RST_CLOCK_PERIOD;
        end else if (cfg_wr) begin
            case (cfg_idx)
                dip_pkg::REG_ACTIVE_TIMEOUT: r_active_to    <= pwdata;
                dip_pkg::REG_DIM_TIMEOUT:    r_dim_to       <= pwdata;
                dip_pkg::REG_DIM_LEVEL:      r_dim_level    <= pwdata[dip_pkg::PCT_W-1:0];
                dip_pkg::REG_TAP_WINDOW:     r_tap_window   <= pwdata[dip_pkg::TAP_W-1:0];
                dip_pkg::REG_SWIPE_DIST:     r_swipe_dist   <= pwdata[dip_pkg::SWIPE_W-1:0];
                dip_pkg::REG_CLOCK_PERIOD:   r_clock_period <= pwdata[dip_pkg::CLK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            dip_pkg::REG_ACTIVE_TIMEOUT: prdata = r_active_to;
            dip_pkg::REG_DIM_TIMEOUT:    prdata = r_dim_to;
            dip_pkg::REG_DIM_LEVEL:      prdata = dip_pkg::DATA_W'(r_dim_level);
            dip_pkg::REG_TAP_WINDOW:     prdata = dip_pkg::DATA_W'(r_tap_window);
            dip_pkg::REG_SWIPE_DIST:     prdata = dip_pkg::DATA_W'(r_swipe_dist);
            dip_pkg::REG_CLOCK_PERIOD:   prdata = dip_pkg::DATA_W'(r_clock_period);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign q_space         = ~r_cnt[1];
    assign o_s_axis_tready = ~r_in_valid | q_space;
    assign in_acc          = i_s_axis_tvalid & o_s_axis_tready;
    assign proc            = r_in_valid & q_space;
    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign pop             = o_m_axis_tvalid & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= dip_pkg::t_op'(i_s_axis_tuser);
            r_now  <= i_s_axis_tdata[dip_pkg::TIME_W-1:0];
            r_x    <= i_s_axis_tdata[X_LSB +: COORD_WIDTH];
            r_y    <= i_s_axis_tdata[Y_LSB +: COORD_WIDTH];
            r_seen <= i_s_axis_tdata[SEEN_B];
        end
    end

    // ---------------- event evaluation ----------------
    assign dt_act    = r_now - r_last_act;
    assign dt_ref    = r_now - r_last_ref;
    assign dt_tap    = r_now - r_last_tap;
    assign dx        = (r_x > r_org_x) ? (r_x - r_org_x) : (r_org_x - r_x);
    assign dy        = (r_y > r_org_y) ? (r_y - r_org_y) : (r_org_y - r_y);
    assign swipe_hit = (DW'(dx) > DW'(r_swipe_dist)) | (DW'(dy) > DW'(r_swipe_dist));

    always_comb begin
        n_mode       = r_mode;
        n_last_act   = r_last_act;
        n_last_ref   = r_last_ref;
        n_last_tap   = r_last_tap;
        n_org_x      = r_org_x;
        n_org_y      = r_org_y;
        n_swipe_done = r_swipe_done;
        n_res        = '0;

        case (r_op)
            dip_pkg::OP_POLL: begin
                case (r_mode)
                    dip_pkg::MODE_ACTIVE: begin
                        if (dt_act > r_active_to) begin
                            n_mode                   = dip_pkg::MODE_DIM;
                            n_res.save_return_screen = 1'b1;
                            n_res.refresh_clock      = 1'b1;
                            n_last_act               = r_now;
                        end
                    end
                    dip_pkg::MODE_DIM: begin
                        if (dt_act > r_dim_to) begin
                            n_mode = dip_pkg::MODE_OFF;
                        end
                        if (dt_ref > dip_pkg::TIME_W'(r_clock_period)) begin
                            n_res.refresh_clock = 1'b1;
                            n_last_ref          = r_now;
                        end
                    end
                    dip_pkg::MODE_OFF: begin
                        if (r_seen) begin
                            n_mode              = dip_pkg::MODE_DIM;
                            n_res.refresh_clock = 1'b1;
                            n_last_act          = r_now;
                        end else begin
                            n_res.light_sleep = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            dip_pkg::OP_ACTIVITY: begin
                n_last_act = r_now;
            end
            dip_pkg::OP_PRESS: begin
                if (r_mode != dip_pkg::MODE_ACTIVE) begin
                    n_org_x      = r_x;
                    n_org_y      = r_y;
                    n_swipe_done = 1'b0;
                    if (dt_tap < dip_pkg::TIME_W'(r_tap_window)) begin
                        n_mode     = dip_pkg::MODE_OFF;
                        n_last_tap = '0;
                    end else begin
                        n_last_tap = r_now;
                    end
                end
            end
            dip_pkg::OP_DRAG: begin
                if (r_mode != dip_pkg::MODE_ACTIVE && !r_swipe_done && swipe_hit) begin
                    n_swipe_done = 1'b1;
                    n_mode       = dip_pkg::MODE_ACTIVE;
                    n_last_act   = r_now;
                end
            end
            dip_pkg::OP_SLEEP: begin
                n_res.save_return_screen = (r_mode == dip_pkg::MODE_ACTIVE);
                n_mode                   = dip_pkg::MODE_DIM;
                n_res.refresh_clock      = 1'b1;
                n_last_act               = r_now;
            end
            default: ;
        endcase

        n_res.mode = n_mode;
        case (n_mode)
            dip_pkg::MODE_ACTIVE: n_res.backlight_pct = dip_pkg::BL_FULL;
            dip_pkg::MODE_DIM:    n_res.backlight_pct = (r_dim_level > dip_pkg::BL_FULL)
                                                        ? dip_pkg::BL_FULL : r_dim_level;
            default:              n_res.backlight_pct = dip_pkg::BL_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= dip_pkg::MODE_ACTIVE;
            r_last_act   <= '0;
            r_last_ref   <= '0;
            r_last_tap   <= '0;
            r_org_x      <= '0;
            r_org_y      <= '0;
            r_swipe_done <= 1'b0;
        end else if (proc) begin
            r_mode       <= n_mode;
            r_last_act   <= n_last_act;
            r_last_ref   <= n_last_ref;
            r_last_tap   <= n_last_tap;
            r_org_x      <= n_org_x;
            r_org_y      <= n_org_y;
            r_swipe_done <= n_swipe_done;
        end
    end

    // ---------------- result queue ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (proc) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({proc, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_q[r_wr_ptr] <= n_res;
        end
    end

    assign o_m_axis_tdata = dip_pkg::OUT_W'(r_q[r_rd_ptr]);

endmodule

`default_nettype wire

[sv/dip_checker.sv]
// Port-level checker for the display idle power controller, with its bind.
// Depends on dip_pkg and display_idle_power_controller_assert.svh.
`default_nettype none

`include "display_idle_power_controller_assert.svh"

module dip_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_out_valid,
    input wire                       i_out_ready,
    input wire [dip_pkg::OUT_W-1:0]  i_out_data
);

    dip_pkg::t_result res;

    assign res = dip_pkg::t_result'(i_out_data[dip_pkg::RES_W-1:0]);

    `DIP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_data), "result changed while stalled")

    `DIP_ASSERT_NOW(a_mode_legal, i_clk, i_rst_n, i_out_valid,
        res.mode == dip_pkg::MODE_ACTIVE || res.mode == dip_pkg::MODE_DIM ||
        res.mode == dip_pkg::MODE_OFF, "illegal mode code")

    `DIP_ASSERT_NOW(a_backlight, i_clk, i_rst_n, i_out_valid,
        (res.mode != dip_pkg::MODE_ACTIVE || res.backlight_pct == dip_pkg::BL_FULL) &&
        (res.mode != dip_pkg::MODE_OFF || res.backlight_pct == dip_pkg::BL_NONE),
        "backlight does not match mode")

    `DIP_ASSERT_NOW(a_sleep_off, i_clk, i_rst_n, i_out_valid && res.light_sleep,
        res.mode == dip_pkg::MODE_OFF && !res.refresh_clock && !res.save_return_screen,
        "light sleep outside off mode")

    `DIP_ASSERT_NOW(a_save_dim, i_clk, i_rst_n, i_out_valid && res.save_return_screen,
        res.mode == dip_pkg::MODE_DIM && res.refresh_clock, "screen save without dim entry")

endmodule

bind display_idle_power_controller dip_checker u_dip_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_m_axis_tvalid),
    .i_out_ready (i_m_axis_tready),
    .i_out_data  (o_m_axis_tdata)
);

`default_nettype wire
